// ===== rtl/tts_pkg.sv =====
// shared types, codes and helpers for the triangular table store
package tts_pkg;

   localparam int MAX_ROWS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 32;
   localparam int DEPTH_DEF      = MAX_ROWS_DEF * (MAX_ROWS_DEF + 1) / 2;
   localparam int ADDR_BITS_DEF  = (DEPTH_DEF > 1) ? $clog2(DEPTH_DEF) : 1;

   localparam int CMD_BITS   = 2;
   localparam int ROW_BITS   = 6;
   localparam int WORD_BITS  = 32;
   localparam int IDX_BITS   = 12;

   localparam logic [ROW_BITS-1:0] ROWS_RESET = ROW_BITS'(1);

   localparam logic [CMD_BITS-1:0] CMD_WRITE  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_MIRROR = 2'd2;

   typedef struct packed {
      logic [CMD_BITS-1:0]         cmd;
      logic [ROW_BITS-1:0]         row;
      logic [ROW_BITS-1:0]         col;
      logic signed [WORD_BITS-1:0] write_value;
   } tts_req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] read_value;
      logic                        status;
   } tts_rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS,
      ST_RD_DATA,
      ST_M_ROW,
      ST_M_PAIR,
      ST_M_RD_A,
      ST_M_RD_B,
      ST_M_WR_A,
      ST_M_WR_B,
      ST_DONE
   } tts_state_type;

   // packed position row*(row+1)/2+col
   function automatic logic [IDX_BITS-1:0] tri_index(input logic [ROW_BITS-1:0] row,
                                                     input logic [ROW_BITS-1:0] col);
      logic [IDX_BITS-1:0] prod;
      prod = IDX_BITS'(row) * (IDX_BITS'(row) + IDX_BITS'(1));
      return (prod >> 1) + IDX_BITS'(col);
   endfunction

endpackage

// ===== rtl/tts_store.sv =====
// entry memory, one write and one registered read port
module tts_store import tts_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF,
   parameter int AW    = ADDR_BITS_DEF,
   parameter int VW    = VALUE_BITS_DEF
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [VW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [VW-1:0] rd_data
);

   logic [VW-1:0] entry_mem_ff [DEPTH];
   logic [VW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tts_seq.sv =====
// sequencer: clearing pass, entry access and row mirror over the shared memory port
module tts_seq import tts_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF,
   parameter int AW    = ADDR_BITS_DEF,
   parameter int VW    = VALUE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  tts_req_type         in_data,
   output logic                in_ready,
   input  logic [ROW_BITS-1:0] used_rows,
   input  logic                out_free,
   output logic                out_valid,
   output tts_rsp_type         out_data,
   output logic                mem_wr_en,
   output logic [AW-1:0]       mem_wr_addr,
   output logic [VW-1:0]       mem_wr_data,
   output logic                mem_rd_en,
   output logic [AW-1:0]       mem_rd_addr,
   input  logic [VW-1:0]       mem_rd_data
);

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   tts_state_type state_ff, state_in;
   logic [CMD_BITS-1:0]  cmd_ff, cmd_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [ROW_BITS-1:0]  col_ff, col_in;
   logic [VW-1:0]        wval_ff, wval_in;
   logic [VW-1:0]        tmp_ff, tmp_in;
   logic                 status_ff, status_in;
   logic [WORD_BITS-1:0] rval_ff, rval_in;
   logic [AW-1:0]        a_ff, a_in;
   logic [AW-1:0]        b_ff, b_in;
   logic [AW-1:0]        base_ff, base_in;
   logic [AW-1:0]        last_ff, last_in;

   logic          accept;
   logic          addr_bad;
   logic          pair_left;
   logic          row_last;
   logic [AW-1:0] acc_addr;

   assign accept    = in_valid && (state_ff == ST_IDLE);
   assign addr_bad  = (in_data.row >= used_rows) || (in_data.col > in_data.row);
   assign pair_left = a_ff < b_ff;
   assign row_last  = ROW_BITS'(row_ff + ROW_BITS'(1)) == used_rows;
   assign acc_addr  = AW'(tri_index(row_ff, col_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (a_ff == LAST_ADDR) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (in_valid) begin
               unique case (in_data.cmd) inside
                  CMD_WRITE, CMD_READ: state_in = addr_bad ? ST_DONE : ST_ACCESS;
                  CMD_MIRROR:          state_in = ST_M_ROW;
                  default:             state_in = ST_DONE;
               endcase
            end
         end
         ST_ACCESS: begin
            state_in = (cmd_ff == CMD_WRITE) ? ST_DONE : ST_RD_DATA;
         end
         ST_RD_DATA: state_in = ST_DONE;
         ST_M_ROW:   state_in = ST_M_PAIR;
         ST_M_PAIR: begin
            if (pair_left) begin
               state_in = ST_M_RD_A;
            end else begin
               state_in = row_last ? ST_DONE : ST_M_ROW;
            end
         end
         ST_M_RD_A: state_in = ST_M_RD_B;
         ST_M_RD_B: state_in = ST_M_WR_A;
         ST_M_WR_A: state_in = ST_M_WR_B;
         ST_M_WR_B: state_in = ST_M_PAIR;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = a_ff;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = a_ff;
      out_valid   = 1'b0;
      in_ready    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         ST_IDLE: begin
            in_ready = 1'b1;
         end
         ST_ACCESS: begin
            if (cmd_ff == CMD_WRITE) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = acc_addr;
               mem_wr_data = wval_ff;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = acc_addr;
            end
         end
         ST_M_RD_A: begin
            mem_rd_en = 1'b1;
         end
         ST_M_RD_B: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = b_ff;
         end
         ST_M_WR_A: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data;
         end
         ST_M_WR_B: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = b_ff;
            mem_wr_data = tmp_ff;
         end
         ST_DONE: begin
            out_valid = out_free;
         end
         default: begin
            mem_wr_en = 1'b0;
         end
      endcase
   end

   assign out_data.read_value = rval_ff;
   assign out_data.status     = status_ff;

   // datapath
   always_comb begin
      cmd_in    = cmd_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      wval_in   = wval_ff;
      tmp_in    = tmp_ff;
      status_in = status_ff;
      rval_in   = rval_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      base_in   = base_ff;
      last_in   = last_ff;
      case (state_ff)
         ST_CLEAR: begin
            a_in = AW'(a_ff + AW'(1));
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in  = in_data.cmd;
               row_in  = in_data.row;
               col_in  = in_data.col;
               wval_in = VW'($signed(in_data.write_value));
               rval_in = '0;
               base_in = '0;
               last_in = '0;
               unique case (in_data.cmd) inside
                  CMD_WRITE, CMD_READ: status_in = addr_bad;
                  CMD_MIRROR: begin
                     status_in = 1'b0;
                     row_in    = '0;
                  end
                  default:             status_in = 1'b1;
               endcase
            end
         end
         ST_RD_DATA: begin
            rval_in = WORD_BITS'($signed(mem_rd_data));
         end
         ST_M_ROW: begin
            a_in = base_ff;
            b_in = last_ff;
         end
         ST_M_PAIR: begin
            if (!pair_left) begin
               row_in  = ROW_BITS'(row_ff + ROW_BITS'(1));
               base_in = AW'(last_ff + AW'(1));
               last_in = AW'(last_ff + AW'(row_ff) + AW'(2));
            end
         end
         ST_M_RD_B: begin
            tmp_in = mem_rd_data;
         end
         ST_M_WR_B: begin
            a_in = AW'(a_ff + AW'(1));
            b_in = AW'(b_ff - AW'(1));
         end
         default: begin
            tmp_in = tmp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         a_ff     <= '0;
      end else begin
         state_ff <= state_in;
         a_ff     <= a_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      wval_ff   <= wval_in;
      tmp_ff    <= tmp_in;
      status_ff <= status_in;
      rval_ff   <= rval_in;
      b_ff      <= b_in;
      base_ff   <= base_in;
      last_ff   <= last_in;
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted word did not start work");

   a_swap_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_M_RD_A |-> pair_left)
      else $error("swap started on crossed addresses");

   a_access_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACCESS |-> !status_ff && acc_addr <= LAST_ADDR)
      else $error("memory access for a bad address");

   a_second_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_M_WR_B |-> $past(state_ff) == ST_M_WR_A)
      else $error("swap write out of sequence");

endmodule

// ===== rtl/triangular_table_store_top.sv =====
// triangular table store: row count register, result register, sequencer and memory
// write: access then done state; read: access, read data, done; one word at a time
// mirror: row by row, each pair swaps by two reads then two writes through one memory port
// reset: memory cleared one entry per cycle, MAX_ROWS*(MAX_ROWS+1)/2 entries (528 default)
// req_stall stays high during the clearing pass; rows_in_use resets to 1
module triangular_table_store_top import tts_pkg::*; #(
   parameter int MAX_ROWS   = MAX_ROWS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  tts_req_type         req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output tts_rsp_type         rsp_data,
   input  logic                csr_wr_en,
   input  logic [ROW_BITS-1:0] csr_wr_data
);

   localparam int STORE_DEPTH = MAX_ROWS * (MAX_ROWS + 1) / 2;
   localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int ROWS_CAP    = (MAX_ROWS < 63) ? MAX_ROWS : 63;

   logic [ROW_BITS-1:0] rows_in_use_ff;
   logic [ROW_BITS-1:0] used_rows;
   logic                rsp_valid_ff, rsp_valid_in;
   tts_rsp_type         rsp_data_ff;
   logic                in_ready;
   logic                out_free;
   logic                out_valid;
   tts_rsp_type         out_data;

   logic                 mem_wr_en;
   logic [ADDR_BITS-1:0] mem_wr_addr;
   logic [VALUE_BITS-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [ADDR_BITS-1:0] mem_rd_addr;
   logic [VALUE_BITS-1:0] mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff <= ROWS_RESET;
      end else if (csr_wr_en) begin
         rows_in_use_ff <= csr_wr_data;
      end
   end

   // zero acts as one, above the table size clamps
   always_comb begin
      if (rows_in_use_ff == '0) begin
         used_rows = ROW_BITS'(1);
      end else if (int'(rows_in_use_ff) > MAX_ROWS) begin
         used_rows = ROW_BITS'(ROWS_CAP);
      end else begin
         used_rows = rows_in_use_ff;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !in_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid) begin
         rsp_data_ff <= out_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   tts_seq #(
      .DEPTH (STORE_DEPTH),
      .AW    (ADDR_BITS),
      .VW    (VALUE_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_data     (req_data),
      .in_ready    (in_ready),
      .used_rows   (used_rows),
      .out_free    (out_free),
      .out_valid   (out_valid),
      .out_data    (out_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   tts_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (ADDR_BITS),
      .VW    (VALUE_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== tb/triangular_table_store_checker.sv =====
// checker for the triangular table store: tracks the table, predicts each answer and compares
module triangular_table_store_checker import tts_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  tts_req_type         req_data,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  tts_rsp_type         rsp_data,
   input  logic                csr_wr_en,
   input  logic [ROW_BITS-1:0] csr_wr_data,
   output int                  fail_count,
   output int                  pending
);

   localparam int TRI_ROWS  = MAX_ROWS_DEF;
   localparam int TRI_DEPTH = TRI_ROWS * (TRI_ROWS + 1) / 2;

   logic signed [WORD_BITS-1:0] tri_mem [TRI_DEPTH];
   logic [ROW_BITS-1:0]         rows_reg;
   tts_rsp_type                 answers_due [$];

   function automatic int live_rows();
      int r;
      r = int'(rows_reg);
      if (r == 0) r = 1;
      if (r > TRI_ROWS) r = TRI_ROWS;
      return r;
   endfunction

   function automatic void reverse_rows();
      int base;
      int a;
      int b;
      logic signed [WORD_BITS-1:0] held;
      for (int i = 0; i < live_rows(); i++) begin
         base = i * (i + 1) / 2;
         for (int j = 0; j < (i + 1) / 2; j++) begin
            a = base + j;
            b = base + i - j;
            held = tri_mem[a];
            tri_mem[a] = tri_mem[b];
            tri_mem[b] = held;
         end
      end
   endfunction

   function automatic tts_rsp_type access_table(tts_req_type w);
      tts_rsp_type ans;
      int pos;
      ans.read_value = '0;
      ans.status = 1'b0;
      pos = int'(w.row) * (int'(w.row) + 1) / 2 + int'(w.col);
      case (w.cmd) inside
         CMD_WRITE, CMD_READ: begin
            if (int'(w.row) >= live_rows() || w.col > w.row || pos >= TRI_DEPTH) begin
               ans.status = 1'b1;
            end else if (w.cmd == CMD_WRITE) begin
               tri_mem[pos] = w.write_value;
            end else begin
               ans.read_value = tri_mem[pos];
            end
         end
         CMD_MIRROR: reverse_rows();
         default: ans.status = 1'b1;
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      tts_rsp_type due;
      if (reset) begin
         for (int k = 0; k < TRI_DEPTH; k++) tri_mem[k] = '0;
         rows_reg = ROWS_RESET;
         answers_due.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $error("unexpected word: read_value %0d status %0d",
                      rsp_data.read_value, rsp_data.status);
               fail_count++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_data.read_value !== due.read_value) begin
                  $error("read_value: expected %0d, got %0d",
                         due.read_value, rsp_data.read_value);
                  fail_count++;
               end
               if (rsp_data.status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_data.status);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en) rows_reg = csr_wr_data;
         if (req_valid && !req_stall) answers_due.push_back(access_table(req_data));
      end
      pending = answers_due.size();
   end

endmodule

// ===== tb/triangular_table_store_top_tb.sv =====
// testbench top for the triangular table store: clock, reset, stimulus, stalls and verdict
module triangular_table_store_top_tb;
   import tts_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 168;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int ROW_PLAN [10] = '{32, 0, 63, 1, 7, 33, 2, 20, 32, 12};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   tts_req_type         req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   tts_rsp_type         rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [ROW_BITS-1:0] csr_wr_data = '0;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int rows_setting = 1;
   bit hold_request = 1'b0;
   logic [2*ROW_BITS-1:0] recent_spots [$];

   always #2 clock = ~clock;

   triangular_table_store_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   triangular_table_store_checker answer_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("triangular_table_store_top_tb: FAIL");
         $finish;
      end
   end

   function automatic tts_req_type mk(logic [CMD_BITS-1:0] cmd, int row, int col,
                                      logic signed [WORD_BITS-1:0] value);
      tts_req_type w;
      w.cmd = cmd;
      w.row = ROW_BITS'(row);
      w.col = ROW_BITS'(col);
      w.write_value = value;
      return w;
   endfunction

   function automatic int live_span();
      if (rows_setting == 0) return 1;
      if (rows_setting > MAX_ROWS_DEF) return MAX_ROWS_DEF;
      return rows_setting;
   endfunction

   function automatic logic signed [WORD_BITS-1:0] random_value();
      case ($urandom_range(15))
         0: return 32'sh7fff_ffff;
         1: return 32'sh8000_0000;
         2: return -32'sd1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic tts_req_type next_item();
      tts_req_type w;
      int pick;
      int span;
      logic [ROW_BITS-1:0] r;
      logic [ROW_BITS-1:0] c;
      span = live_span();
      pick = $urandom_range(99);
      w.write_value = random_value();
      w.row = ROW_BITS'($urandom_range(span - 1));
      w.col = ROW_BITS'($urandom_range(w.row));
      if (pick < 40) begin
         w.cmd = CMD_WRITE;
         recent_spots.push_back({w.row, w.col});
         if (recent_spots.size() > 16) void'(recent_spots.pop_front());
      end else if (pick < 80) begin
         w.cmd = CMD_READ;
         if (recent_spots.size() > 0 && $urandom_range(1)) begin
            {r, c} = recent_spots[$urandom_range(recent_spots.size() - 1)];
            if (r < span) begin
               w.row = r;
               w.col = c;
            end
         end
      end else if (pick < 86) begin
         w.cmd = CMD_MIRROR;
         w.row = ROW_BITS'($urandom_range(63));
         w.col = ROW_BITS'($urandom_range(63));
      end else if (pick < 96) begin
         w.cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
         w.row = ROW_BITS'($urandom_range(63));
         w.col = ROW_BITS'($urandom_range(63));
      end else begin
         w.cmd = CMD_UNUSED;
         w.row = ROW_BITS'($urandom_range(63));
         w.col = ROW_BITS'($urandom_range(63));
      end
      return w;
   endfunction

   task automatic send_item(tts_req_type w);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pause_sender(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_rows(int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= ROW_BITS'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      rows_setting = value;
   endtask

   initial begin : receiver
      int pct;
      int span;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         case ($urandom_range(3))
            0: pct = 0;
            1: pct = 25;
            2: pct = 60;
            default: pct = 90;
         endcase
         span = $urandom_range(10, 150);
         repeat (span) begin
            @(negedge clock);
            if (hold_request && !hold_done) begin
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(negedge clock);
               hold_done = 1'b1;
            end
            rsp_stall <= ($urandom_range(99) < pct);
         end
      end
   end

   initial begin : stimulus
      int sent;
      int burst;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset row count of one
      send_item(mk(CMD_READ, 0, 0, 0));
      send_item(mk(CMD_WRITE, 1, 0, 32'sd55));
      send_item(mk(CMD_WRITE, 0, 0, 32'sh8000_0000));
      send_item(mk(CMD_READ, 0, 0, 0));
      drain();
      write_rows(32);

      send_item(mk(CMD_WRITE, 31, 31, 32'sh7fff_ffff));
      send_item(mk(CMD_WRITE, 31, 0, -32'sd1));
      send_item(mk(CMD_WRITE, 5, 2, 32'sd12345));
      send_item(mk(CMD_READ, 31, 31, 0));
      send_item(mk(CMD_READ, 31, 0, 0));
      send_item(mk(CMD_READ, 32, 0, 0));
      send_item(mk(CMD_READ, 3, 4, 0));
      send_item(mk(CMD_WRITE, 63, 63, -32'sd1));
      send_item(mk(CMD_READ, 63, 0, 0));
      send_item(mk(CMD_UNUSED, 63, 63, -32'sd1));
      send_item(mk(CMD_MIRROR, 0, 0, 0));
      send_item(mk(CMD_READ, 31, 0, 0));
      send_item(mk(CMD_READ, 31, 31, 0));
      send_item(mk(CMD_READ, 5, 3, 0));
      send_item(mk(CMD_READ, 0, 0, 0));
      send_item(mk(CMD_WRITE, 10, 10, 32'sd0));
      send_item(mk(CMD_MIRROR, 63, 63, 0));
      send_item(mk(CMD_READ, 5, 2, 0));

      foreach (ROW_PLAN[p]) begin
         drain();
         write_rows(ROW_PLAN[p]);
         if (p == 2) hold_request = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
               send_item(next_item());
               sent++;
            end
            case ($urandom_range(3))
               0: pause_sender(0);
               3: pause_sender($urandom_range(10, 40));
               default: pause_sender($urandom_range(1, 6));
            endcase
         end
      end

      drain();
      repeat (32) @(posedge clock);
      if (fail_count == 0) begin
         $display("triangular_table_store_top_tb: PASS");
      end else begin
         $display("triangular_table_store_top_tb: FAIL");
      end
      $finish;
   end

endmodule
